FILE: rtl/smc_pkg.sv
// Package for the static matrix condensation core: command, register index,
// result kind and arithmetic request types shared by the core and its units.
// No dependencies.
package smc_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD_K = 2'd0,
        CMD_LOAD_M = 2'd1,
        CMD_START  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    localparam logic [1:0] REG_FULL_SIZE   = 2'd0;
    localparam logic [1:0] REG_KEPT_SIZE   = 2'd1;
    localparam logic [1:0] REG_MASS_ENABLE = 2'd2;

    localparam logic RK_READ = 1'b0;
    localparam logic RK_DONE = 1'b1;

    typedef enum logic {
        OP_MUL   = 1'b0,
        OP_RECIP = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

endpackage

FILE: rtl/static_matrix_condensation_core.sv
// Static condensation core: holds a stiffness and a mass matrix in two RAMs of
// MAX_DOF*MAX_DOF entries (depends on smc_pkg, smc_ram, smc_arith). A start item
// blocks input until all trailing degrees of freedom are eliminated. The time is
// set by one shared arithmetic unit for products and reciprocals; steps run over
// k from full_size-1 down to kept_size, with more products when mass is on.
// Stores have no reset.
module static_matrix_condensation_core import smc_pkg::*; #(
    parameter int MAX_DOF     = 32,
    parameter int VALUE_WIDTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [4:0]         s_row_index,
    input  logic [4:0]         s_col_index,
    input  logic               s_which_matrix,
    input  logic signed [63:0] s_entry_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_result_kind,
    output logic signed [63:0] m_entry_value,
    output logic               m_status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [5:0]         cfg_data
);

    localparam int IW    = $clog2(MAX_DOF);
    localparam int NW    = $clog2(MAX_DOF + 1);
    localparam int DEPTH = MAX_DOF * MAX_DOF;
    localparam int AW    = $clog2(DEPTH);
    localparam logic signed [63:0] VMAX_S =
        signed'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
    localparam logic signed [63:0] VMIN_S = -VMAX_S - 64'sd1;

    typedef enum logic [20:0] {
        S_IDLE    = 21'd1 << 0,
        S_RDW     = 21'd1 << 1,
        S_PIV_RD  = 21'd1 << 2,
        S_PIV_LAT = 21'd1 << 3,
        S_PIV_REC = 21'd1 << 4,
        S_COL_RD  = 21'd1 << 5,
        S_COL_MUL = 21'd1 << 6,
        S_COL_WB  = 21'd1 << 7,
        S_UC_RD   = 21'd1 << 8,
        S_UC_LAT  = 21'd1 << 9,
        S_UR_RD   = 21'd1 << 10,
        S_UR_LAT  = 21'd1 << 11,
        S_UR_DAT  = 21'd1 << 12,
        S_MK1     = 21'd1 << 13,
        S_MK2     = 21'd1 << 14,
        S_MM1     = 21'd1 << 15,
        S_MM2     = 21'd1 << 16,
        S_MM3     = 21'd1 << 17,
        S_MM4     = 21'd1 << 18,
        S_MWB     = 21'd1 << 19,
        S_FIN     = 21'd1 << 20
    } state_t;

    function automatic logic signed [63:0] sat65(input logic signed [64:0] x);
        logic signed [63:0] y;
        if (x > 65'(VMAX_S)) begin
            y = VMAX_S;
        end else if (x < 65'(VMIN_S)) begin
            y = VMIN_S;
        end else begin
            y = x[63:0];
        end
        return y;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r,
                                               input logic [IW-1:0] c);
        return AW'(32'(r) * MAX_DOF + 32'(c));
    endfunction

    state_t             state_reg, state_next;
    logic [5:0]         full_size_reg, full_size_next;
    logic [5:0]         kept_size_reg, kept_size_next;
    logic               mass_en_reg, mass_en_next;
    logic               zflag_reg, zflag_next;
    logic [IW-1:0]      k_reg, k_next;
    logic [IW-1:0]      r_reg, r_next;
    logic [IW-1:0]      c_reg, c_next;
    logic [NW-1:0]      kept_reg, kept_next;
    logic               rd_sel_reg, rd_sel_next;
    logic               rd_in_reg, rd_in_next;
    logic signed [63:0] p_reg, p_next;
    logic signed [63:0] ninv_reg, ninv_next;
    logic signed [63:0] vc_reg, vc_next;
    logic signed [63:0] vr_reg, vr_next;
    logic signed [63:0] mkk_reg, mkk_next;
    logic signed [63:0] mkc_reg, mkc_next;
    logic signed [63:0] mkr_reg, mkr_next;
    logic signed [63:0] krc_reg, krc_next;
    logic signed [63:0] mrc_reg, mrc_next;
    logic signed [63:0] acc_reg, acc_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_kind_reg, m_kind_next;
    logic signed [63:0] m_value_reg, m_value_next;
    logic               m_status_reg, m_status_next;

    logic                   k_we, m_we;
    logic [AW-1:0]          k_waddr, m_waddr, k_raddr, m_raddr;
    logic [VALUE_WIDTH-1:0] k_wdata, m_wdata, k_rdata, m_rdata;
    logic signed [63:0]     kval, mval, load_val;
    arith_req_t             areq;
    logic signed [63:0]     op_a, op_b, arith_res;
    logic                   arith_done;

    logic          in_range, accept;
    logic [AW-1:0] port_addr;
    logic [6:0]    fs7, full7, ks7, kept7;
    logic          last_r, last_c, more_steps;

    smc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_kram (
        .aclk(aclk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .raddr(k_raddr), .rdata(k_rdata)
    );

    smc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_mram (
        .aclk(aclk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );

    smc_arith #(.VALUE_WIDTH(VALUE_WIDTH)) u_arith (
        .aclk(aclk), .aresetn(aresetn), .req(areq), .op_a(op_a), .op_b(op_b),
        .done(arith_done), .result(arith_res)
    );

    assign kval = 64'(signed'(k_rdata));
    assign mval = 64'(signed'(m_rdata));
    assign load_val = (s_entry_in > VMAX_S) ? VMAX_S :
                      ((s_entry_in < VMIN_S) ? VMIN_S : s_entry_in);

    assign in_range  = (7'(s_row_index) < 7'(MAX_DOF)) && (7'(s_col_index) < 7'(MAX_DOF));
    assign port_addr = addr_of(IW'(s_row_index), IW'(s_col_index));

    assign fs7   = 7'(full_size_reg);
    assign full7 = (fs7 == 7'd0) ? 7'd1 : ((fs7 > 7'(MAX_DOF)) ? 7'(MAX_DOF) : fs7);
    assign ks7   = 7'(kept_size_reg);
    assign kept7 = (ks7 > full7) ? full7 : ks7;

    assign last_r     = r_reg == (k_reg - 1'b1);
    assign last_c     = c_reg == (k_reg - 1'b1);
    assign more_steps = NW'(k_reg) > kept_reg;

    assign s_ready = (state_reg == S_IDLE) &&
                     ((s_command == CMD_LOAD_K) || (s_command == CMD_LOAD_M) ||
                      !m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next     = state_reg;
        full_size_next = full_size_reg;
        kept_size_next = kept_size_reg;
        mass_en_next   = mass_en_reg;
        zflag_next     = zflag_reg;
        k_next         = k_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        kept_next      = kept_reg;
        rd_sel_next    = rd_sel_reg;
        rd_in_next     = rd_in_reg;
        p_next         = p_reg;
        ninv_next      = ninv_reg;
        vc_next        = vc_reg;
        vr_next        = vr_reg;
        mkk_next       = mkk_reg;
        mkc_next       = mkc_reg;
        mkr_next       = mkr_reg;
        krc_next       = krc_reg;
        mrc_next       = mrc_reg;
        acc_next       = acc_reg;
        m_valid_next   = m_valid_reg;
        m_kind_next    = m_kind_reg;
        m_value_next   = m_value_reg;
        m_status_next  = m_status_reg;
        k_we           = 1'b0;
        m_we           = 1'b0;
        k_waddr        = addr_of(r_reg, c_reg);
        m_waddr        = addr_of(r_reg, c_reg);
        k_wdata        = VALUE_WIDTH'(arith_res);
        m_wdata        = VALUE_WIDTH'(sat65(65'(mrc_reg) + 65'(acc_reg)));
        k_raddr        = addr_of(k_reg, k_reg);
        m_raddr        = addr_of(k_reg, k_reg);
        areq.start     = 1'b0;
        areq.op        = OP_MUL;
        op_a           = arith_res;
        op_b           = vc_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_FULL_SIZE:   full_size_next = cfg_data;
                REG_KEPT_SIZE:   kept_size_next = cfg_data;
                REG_MASS_ENABLE: mass_en_next   = cfg_data[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                k_raddr = port_addr;
                m_raddr = port_addr;
                if (accept) begin
                    unique case (cmd_t'(s_command))
                        CMD_LOAD_K: begin
                            k_we    = in_range;
                            k_waddr = port_addr;
                            k_wdata = VALUE_WIDTH'(load_val);
                        end
                        CMD_LOAD_M: begin
                            m_we    = in_range;
                            m_waddr = port_addr;
                            m_wdata = VALUE_WIDTH'(load_val);
                        end
                        CMD_READ: begin
                            rd_sel_next = s_which_matrix;
                            rd_in_next  = in_range;
                            state_next  = S_RDW;
                        end
                        default: begin
                            zflag_next = 1'b0;
                            kept_next  = NW'(kept7);
                            k_next     = IW'(full7 - 7'd1);
                            state_next = (full7 > kept7) ? S_PIV_RD : S_FIN;
                        end
                    endcase
                end
            end
            S_RDW: begin
                m_valid_next  = 1'b1;
                m_kind_next   = RK_READ;
                m_value_next  = rd_in_reg ? (rd_sel_reg ? mval : kval) : 64'sd0;
                m_status_next = zflag_reg;
                state_next    = S_IDLE;
            end
            S_PIV_RD: begin
                state_next = S_PIV_LAT;
            end
            S_PIV_LAT: begin
                p_next     = kval;
                mkk_next   = mval;
                if (kval == 64'sd0) begin
                    zflag_next = 1'b1;
                end
                areq.start = 1'b1;
                areq.op    = OP_RECIP;
                op_a       = kval;
                state_next = S_PIV_REC;
            end
            S_PIV_REC: begin
                if (arith_done) begin
                    k_we      = 1'b1;
                    k_waddr   = addr_of(k_reg, k_reg);
                    ninv_next = sat65(65'sd0 - 65'(arith_res));
                    r_next    = '0;
                    c_next    = '0;
                    if (k_reg == '0) begin
                        state_next = S_FIN;
                    end else begin
                        state_next = S_COL_RD;
                    end
                end
            end
            S_COL_RD: begin
                k_raddr    = addr_of(r_reg, k_reg);
                state_next = S_COL_MUL;
            end
            S_COL_MUL: begin
                areq.start = 1'b1;
                op_a       = kval;
                op_b       = ninv_reg;
                state_next = S_COL_WB;
            end
            S_COL_WB: begin
                if (arith_done) begin
                    k_we    = 1'b1;
                    k_waddr = addr_of(r_reg, k_reg);
                    if (last_r) begin
                        r_next     = '0;
                        state_next = S_UC_RD;
                    end else begin
                        r_next     = r_reg + 1'b1;
                        state_next = S_COL_RD;
                    end
                end
            end
            S_UC_RD: begin
                k_raddr    = addr_of(c_reg, k_reg);
                m_raddr    = addr_of(k_reg, c_reg);
                state_next = S_UC_LAT;
            end
            S_UC_LAT: begin
                vc_next    = kval;
                mkc_next   = mval;
                state_next = S_UR_RD;
            end
            S_UR_RD: begin
                k_raddr    = addr_of(r_reg, k_reg);
                m_raddr    = addr_of(k_reg, r_reg);
                state_next = S_UR_LAT;
            end
            S_UR_LAT: begin
                vr_next    = kval;
                mkr_next   = mval;
                k_raddr    = addr_of(r_reg, c_reg);
                m_raddr    = addr_of(r_reg, c_reg);
                state_next = S_UR_DAT;
            end
            S_UR_DAT: begin
                krc_next   = kval;
                mrc_next   = mval;
                areq.start = 1'b1;
                op_a       = p_reg;
                op_b       = vr_reg;
                state_next = S_MK1;
            end
            S_MK1: begin
                if (arith_done) begin
                    areq.start = 1'b1;
                    state_next = S_MK2;
                end
            end
            S_MK2: begin
                if (arith_done) begin
                    k_we    = 1'b1;
                    k_wdata = VALUE_WIDTH'(sat65(65'(krc_reg) - 65'(arith_res)));
                    if (mass_en_reg) begin
                        areq.start = 1'b1;
                        op_a       = vc_reg;
                        op_b       = mkr_reg;
                        state_next = S_MM1;
                    end else begin
                        state_next = S_MWB;
                    end
                end
            end
            S_MM1: begin
                if (arith_done) begin
                    acc_next   = arith_res;
                    areq.start = 1'b1;
                    op_a       = vr_reg;
                    op_b       = mkc_reg;
                    state_next = S_MM2;
                end
            end
            S_MM2: begin
                if (arith_done) begin
                    acc_next   = sat65(65'(acc_reg) + 65'(arith_res));
                    areq.start = 1'b1;
                    op_a       = vr_reg;
                    op_b       = mkk_reg;
                    state_next = S_MM3;
                end
            end
            S_MM3: begin
                if (arith_done) begin
                    areq.start = 1'b1;
                    state_next = S_MM4;
                end
            end
            S_MM4: begin
                if (arith_done) begin
                    acc_next   = sat65(65'(acc_reg) + 65'(arith_res));
                    state_next = S_MWB;
                end
            end
            S_MWB: begin
                m_we = mass_en_reg;
                if (!last_r) begin
                    r_next     = r_reg + 1'b1;
                    state_next = S_UR_RD;
                end else if (!last_c) begin
                    r_next     = '0;
                    c_next     = c_reg + 1'b1;
                    state_next = S_UC_RD;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (more_steps) begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_PIV_RD;
                end else begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = RK_DONE;
                    m_value_next  = 64'sd0;
                    m_status_next = zflag_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            full_size_reg <= 6'd32;
            kept_size_reg <= 6'd1;
            mass_en_reg   <= 1'b0;
            zflag_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            k_reg         <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            kept_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            full_size_reg <= full_size_next;
            kept_size_reg <= kept_size_next;
            mass_en_reg   <= mass_en_next;
            zflag_reg     <= zflag_next;
            m_valid_reg   <= m_valid_next;
            k_reg         <= k_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            kept_reg      <= kept_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_sel_reg   <= rd_sel_next;
        rd_in_reg    <= rd_in_next;
        p_reg        <= p_next;
        ninv_reg     <= ninv_next;
        vc_reg       <= vc_next;
        vr_reg       <= vr_next;
        mkk_reg      <= mkk_next;
        mkc_reg      <= mkc_next;
        mkr_reg      <= mkr_next;
        krc_reg      <= krc_next;
        mrc_reg      <= mrc_next;
        acc_reg      <= acc_next;
        m_kind_reg   <= m_kind_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_entry_value = m_value_reg;
    assign m_status      = m_status_reg;

endmodule

FILE: rtl/smc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module smc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/smc_arith.sv
// Multi-cycle Q32.32 arithmetic unit: rounded saturating product from four
// 32x32 partial products, and rounded reciprocal by restoring division.
// Depends on smc_pkg.
module smc_arith import smc_pkg::*; #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  arith_req_t         req,
    input  logic signed [63:0] op_a,
    input  logic signed [63:0] op_b,
    output logic               done,
    output logic signed [63:0] result
);

    localparam logic [63:0] VMAX = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
    localparam logic [63:0] LIM  = VMAX + 64'd1;

    typedef enum logic [4:0] {
        A_IDLE = 5'b00001,
        A_MUL  = 5'b00010,
        A_DIV  = 5'b00100,
        A_RND  = 5'b01000,
        A_FIN  = 5'b10000
    } astate_t;

    astate_t            state_reg, state_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic [63:0]        ua_reg, ua_next;
    logic [63:0]        ub_reg, ub_next;
    logic               neg_reg, neg_next;
    logic [63:0]        pp_reg, pp_next;
    logic [127:0]       acc_reg, acc_next;
    logic [64:0]        rem_reg, rem_next;
    logic [64:0]        quo_reg, quo_next;
    logic [64:0]        mag_reg, mag_next;
    logic signed [63:0] res_reg, res_next;
    logic               done_reg, done_next;

    logic [63:0]  a_mag, b_mag;
    logic [31:0]  a_half, b_half;
    logic [63:0]  pp_prod;
    logic [1:0]   prev;
    logic [127:0] addend, acc_sum;
    logic [64:0]  rem_sh, rem_sub;
    logic         rem_ge, rnd_up;
    logic [63:0]  fin_mag;

    assign a_mag   = op_a[63] ? (64'd0 - 64'(op_a)) : 64'(op_a);
    assign b_mag   = op_b[63] ? (64'd0 - 64'(op_b)) : 64'(op_b);
    assign a_half  = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
    assign b_half  = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
    assign pp_prod = {32'd0, a_half} * {32'd0, b_half};
    assign prev    = cnt_reg[1:0] - 2'd1;
    assign acc_sum = acc_reg + addend;
    assign rem_sh  = {rem_reg[63:0], (cnt_reg == 7'd0)};
    assign rem_ge  = rem_sh >= {1'b0, ua_reg};
    assign rem_sub = rem_sh - {1'b0, ua_reg};
    assign rnd_up  = {rem_reg, 1'b0} >= {2'b00, ua_reg};

    always_comb begin
        unique case (prev)
            2'd0:    addend = {64'd0, pp_reg};
            2'd1,
            2'd2:    addend = {32'd0, pp_reg, 32'd0};
            default: addend = {pp_reg, 64'd0};
        endcase
    end

    always_comb begin
        if (neg_reg) begin
            fin_mag = (mag_reg > {1'b0, LIM}) ? LIM : mag_reg[63:0];
        end else begin
            fin_mag = (mag_reg > {1'b0, VMAX}) ? VMAX : mag_reg[63:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ua_next    = ua_reg;
        ub_next    = ub_reg;
        neg_next   = neg_reg;
        pp_next    = pp_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        mag_next   = mag_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    ua_next  = a_mag;
                    ub_next  = b_mag;
                    cnt_next = 7'd0;
                    if (req.op == OP_MUL) begin
                        neg_next   = op_a[63] ^ op_b[63];
                        acc_next   = 128'h8000_0000;
                        state_next = A_MUL;
                    end else if (op_a == 64'sd0) begin
                        res_next  = 64'sd0;
                        done_next = 1'b1;
                    end else begin
                        neg_next   = op_a[63];
                        rem_next   = 65'd0;
                        quo_next   = 65'd0;
                        state_next = A_DIV;
                    end
                end
            end
            A_MUL: begin
                if (cnt_reg == 7'd4) begin
                    mag_next   = {|acc_sum[127:96], acc_sum[95:32]};
                    state_next = A_FIN;
                end else begin
                    pp_next = pp_prod;
                    if (cnt_reg != 7'd0) begin
                        acc_next = acc_sum;
                    end
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            A_DIV: begin
                rem_next = rem_ge ? rem_sub : rem_sh;
                quo_next = {quo_reg[63:0], rem_ge};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd64) begin
                    state_next = A_RND;
                end
            end
            A_RND: begin
                mag_next   = quo_reg + {64'd0, rnd_up};
                state_next = A_FIN;
            end
            A_FIN: begin
                res_next   = neg_reg ? signed'(64'd0 - fin_mag) : signed'(fin_mag);
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        ua_reg  <= ua_next;
        ub_reg  <= ub_next;
        neg_reg <= neg_next;
        pp_reg  <= pp_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        mag_reg <= mag_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

FILE: rtl/smc_checker.sv
// Port-level checker for the static condensation core, bound to the top level.
// Depends on smc_pkg and static_matrix_condensation_core.
module smc_checker import smc_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_command,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_result_kind,
    input logic signed [63:0] m_entry_value
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_entry_value))
        else $error("result item changed while stalled");

    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == RK_DONE) |-> m_entry_value == 64'sd0)
        else $error("finished item carries a nonzero value");

    a_start_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_command == CMD_START) |=> !s_ready)
        else $error("input taken right after start");

    a_read_answers: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_command == CMD_READ) |=> ##1 m_valid)
        else $error("read item produced no result");

endmodule

bind static_matrix_condensation_core smc_checker u_smc_checker (.*);

FILE: tb/sv/condensation_checker.sv
// Checker for the static matrix condensation core: watches the config, input
// and result channels, predicts every result in fixed point and compares it.
// Depends on smc_pkg; instantiated by tb_top beside the core.
module condensation_checker import smc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [4:0]         s_row_index,
    input  logic [4:0]         s_col_index,
    input  logic               s_which_matrix,
    input  logic signed [63:0] s_entry_in,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_result_kind,
    input  logic signed [63:0] m_entry_value,
    input  logic               m_status,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [5:0]         cfg_data,
    output int                 errors,
    output int                 pending,
    output int                 checked_cnt,
    output int                 done_cnt,
    output int                 zero_pivot_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DOF = 32;
    localparam logic signed [63:0] QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] QMIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic               kind;
        logic signed [63:0] value;
        logic               status;
    } result_t;

    logic signed [63:0] stiff [DOF][DOF];
    logic signed [63:0] mass  [DOF][DOF];
    logic               pivot_flag;
    logic [5:0]         full_r;
    logic [5:0]         kept_r;
    logic               mass_r;
    result_t            expected_results[$];

    function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] mag,
                                                    input logic ovf);
        if (neg) begin
            if (ovf || mag > 64'h8000_0000_0000_0000) mag = 64'h8000_0000_0000_0000;
            return 64'd0 - mag;
        end
        if (ovf || mag > 64'h7FFF_FFFF_FFFF_FFFF) return QMAX;
        return mag;
    endfunction

    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a, b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] pr;
        ua = a[63] ? 64'd0 - a : a;
        ub = b[63] ? 64'd0 - b : b;
        pr = {64'd0, ua} * {64'd0, ub};
        pr = pr + 128'h8000_0000;
        return from_mag(a[63] ^ b[63], pr[95:32], pr[127:96] != 0);
    endfunction

    function automatic logic signed [63:0] fx_recip(input logic signed [63:0] p);
        logic [63:0]  m;
        logic [129:0] num;
        logic [129:0] q;
        m = p[63] ? 64'd0 - p : p;
        if (m == 64'd1) return from_mag(p[63], 64'd0, 1'b1);
        num = (130'd1 << 65) + {66'd0, m};
        q = num / ({66'd0, m} << 1);
        return from_mag(p[63], q[63:0], 1'b0);
    endfunction

    function automatic logic signed [63:0] fx_add(input logic signed [63:0] a, b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? QMIN : QMAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] fx_sub(input logic signed [63:0] a, b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? QMIN : QMAX;
        return s[63:0];
    endfunction

    task automatic condense();
        int                 eff;
        int                 kept;
        logic signed [63:0] p;
        logic signed [63:0] inv;
        logic signed [63:0] vr;
        logic signed [63:0] vc;
        logic signed [63:0] t;
        eff = (full_r == 0) ? 1 : ((full_r > DOF) ? DOF : int'(full_r));
        kept = (kept_r > eff) ? eff : int'(kept_r);
        pivot_flag = 1'b0;
        for (int k = eff - 1; k >= kept; k--) begin
            p = stiff[k][k];
            if (p == 0) begin
                pivot_flag = 1'b1;
                inv = 0;
            end else begin
                inv = fx_recip(p);
            end
            stiff[k][k] = inv;
            for (int r = 0; r < k; r++) stiff[r][k] = fx_mul(stiff[r][k], fx_sub(0, inv));
            for (int c = 0; c < k; c++) begin
                vc = stiff[c][k];
                for (int r = 0; r < k; r++) begin
                    vr = stiff[r][k];
                    stiff[r][c] = fx_sub(stiff[r][c], fx_mul(fx_mul(p, vr), vc));
                    if (mass_r) begin
                        t = fx_mul(vc, mass[k][r]);
                        t = fx_add(t, fx_mul(vr, mass[k][c]));
                        t = fx_add(t, fx_mul(fx_mul(vr, mass[k][k]), vc));
                        mass[r][c] = fx_add(mass[r][c], t);
                    end
                end
            end
        end
    endtask

    task automatic predict_item();
        result_t res;
        case (cmd_t'(s_command))
            CMD_LOAD_K: stiff[s_row_index][s_col_index] = s_entry_in;
            CMD_LOAD_M: mass[s_row_index][s_col_index] = s_entry_in;
            CMD_START: begin
                condense();
                res.kind = RK_DONE;
                res.value = 0;
                res.status = pivot_flag;
                expected_results.push_back(res);
            end
            default: begin
                res.kind = RK_READ;
                res.value = s_which_matrix ? mass[s_row_index][s_col_index]
                                           : stiff[s_row_index][s_col_index];
                res.status = pivot_flag;
                expected_results.push_back(res);
            end
        endcase
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (errors < 25) $display("mismatch %0t: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            pivot_flag = 1'b0;
            full_r = 6'd32;
            kept_r = 6'd1;
            mass_r = 1'b0;
            errors = 0;
            checked_cnt = 0;
            done_cnt = 0;
            zero_pivot_cnt = 0;
            for (int r = 0; r < DOF; r++) begin
                for (int c = 0; c < DOF; c++) begin
                    stiff[r][c] = 0;
                    mass[r][c] = 0;
                end
            end
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_FULL_SIZE) full_r = cfg_data;
                else if (cfg_index == REG_KEPT_SIZE) kept_r = cfg_data;
                else if (cfg_index == REG_MASS_ENABLE) mass_r = cfg_data[0];
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", m_entry_value, 0);
                end else begin
                    want = expected_results.pop_front();
                    checked_cnt++;
                    if (want.kind == RK_DONE) done_cnt++;
                    if (want.kind == RK_DONE && want.status) zero_pivot_cnt++;
                    if (m_result_kind !== want.kind) report("result_kind", m_result_kind, want.kind);
                    if (m_entry_value !== want.value) report("entry_value", m_entry_value, want.value);
                    if (m_status !== want.status) report("status", m_status, want.status);
                end
            end
            if (s_valid && s_ready) predict_item();
        end
        pending = expected_results.size();
    end
endmodule

FILE: tb/sv/tb_top.sv
// Top of the condensation core testbench: clock, reset, stimulus, receiver
// stalls and verdict. Depends on smc_pkg, the core and condensation_checker.
module tb_top;
    import smc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_NONE = 2'd3;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_command;
    logic [4:0]         s_row_index;
    logic [4:0]         s_col_index;
    logic               s_which_matrix;
    logic signed [63:0] s_entry_in;
    logic               m_valid;
    logic               m_ready;
    logic               m_result_kind;
    logic signed [63:0] m_entry_value;
    logic               m_status;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [5:0]         cfg_data;
    int                 errors;
    int                 pending;
    int                 checked_cnt;
    int                 done_cnt;
    int                 zero_pivot_cnt;

    logic k_wr [32][32];
    logic m_wr [32][32];
    int   burst_left;
    int   items_sent;
    logic hold_req;
    logic big_done;

    static_matrix_condensation_core uut (.*);

    condensation_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(64'd60_000_000);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int   phase;
        logic hold_seen;
        m_ready = 1'b0;
        phase = 0;
        hold_seen = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_ready = 1'b0;
                repeat (400) @(negedge aclk);
            end else begin
                phase++;
                case ((phase / 80) % 3)
                    0: m_ready = 1'b1;
                    1: m_ready = ($urandom_range(0, 1) == 1);
                    default: m_ready = ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    task automatic send_item(input logic [1:0] cmd, input int row, input int col,
                             input logic which, input logic [63:0] val);
        if (burst_left == 0) begin
            s_valid = 1'b0;
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_command = cmd;
        s_row_index = 5'(row);
        s_col_index = 5'(col);
        s_which_matrix = which;
        s_entry_in = val;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
        if (cmd == CMD_LOAD_K) k_wr[row][col] = 1'b1;
        if (cmd == CMD_LOAD_M) m_wr[row][col] = 1'b1;
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [5:0] data);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        s_valid = 1'b0;
        wait (pending == 0);
        repeat (40) @(negedge aclk);
    endtask

    function automatic logic [63:0] wide_val();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] small_val(input int lo, input int hi);
        logic [31:0] ip;
        ip = $urandom_range(0, hi - lo) + lo;
        return {ip, $urandom()};
    endfunction

    task automatic read_any();
        int   r;
        int   c;
        logic w;
        w = 1'($urandom_range(0, 1));
        do begin
            r = $urandom_range(0, 31);
            c = $urandom_range(0, 31);
        end while (!(w ? m_wr[r][c] : k_wr[r][c]));
        send_item(CMD_READ, r, c, w, wide_val());
    endtask

    task automatic load_block(input int n, input logic with_mass, input int zero_row);
        logic [63:0] v;
        for (int r = 0; r < n; r++) begin
            for (int c = r; c < n; c++) begin
                v = (r == c) ? small_val(4, 20) : small_val(-2, 1);
                if ($urandom_range(0, 39) == 0) v = wide_val();
                if (r == zero_row && c == zero_row) v = 0;
                send_item(CMD_LOAD_K, r, c, 1'($urandom_range(0, 1)), v);
                if (r != c) send_item(CMD_LOAD_K, c, r, 1'($urandom_range(0, 1)), v);
                if (with_mass) begin
                    v = (r == c) ? small_val(1, 3) : small_val(-1, 0);
                    send_item(CMD_LOAD_M, r, c, 1'($urandom_range(0, 1)), v);
                    if (r != c) send_item(CMD_LOAD_M, c, r, 1'($urandom_range(0, 1)), v);
                end
                if ($urandom_range(0, 15) == 0) read_any();
            end
        end
    endtask

    task automatic start_item();
        send_item(CMD_START, $urandom_range(0, 31), $urandom_range(0, 31),
                  1'($urandom_range(0, 1)), wide_val());
    endtask

    task automatic run_phase(input logic [5:0] full, input logic [5:0] kept,
                             input logic with_mass);
        int eff;
        int zrow;
        eff = (full == 0) ? 1 : ((full > 32) ? 32 : int'(full));
        zrow = ($urandom_range(0, 4) == 0) ? $urandom_range(0, eff - 1) : -1;
        cfg_write(REG_FULL_SIZE, full);
        cfg_write(REG_KEPT_SIZE, kept);
        cfg_write(REG_MASS_ENABLE, {5'($urandom_range(0, 31)), with_mass});
        repeat ($urandom_range(0, 4)) begin
            send_item(2'($urandom_range(0, 1)), $urandom_range(0, 31), $urandom_range(0, 31),
                      1'($urandom_range(0, 1)), wide_val());
        end
        load_block(eff, with_mass, zrow);
        start_item();
        repeat ($urandom_range(2, 2 * eff + 2)) read_any();
        if ($urandom_range(0, 3) == 0) begin
            start_item();
            repeat (3) read_any();
        end
        drain();
    endtask

    initial begin
        logic [5:0] full;
        logic [5:0] kept;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = CMD_LOAD_K;
        s_row_index = '0;
        s_col_index = '0;
        s_which_matrix = 1'b0;
        s_entry_in = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_FULL_SIZE;
        cfg_data = '0;
        hold_req = 1'b0;
        big_done = 1'b0;
        burst_left = 0;
        items_sent = 0;
        for (int r = 0; r < 32; r++) begin
            for (int c = 0; c < 32; c++) begin
                k_wr[r][c] = 1'b0;
                m_wr[r][c] = 1'b0;
            end
        end
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        repeat (2) @(negedge aclk);

        cfg_write(REG_NONE, 6'h3F);
        send_item(CMD_LOAD_K, 31, 31, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(CMD_LOAD_M, 31, 31, 1'b1, 64'h8000_0000_0000_0000);
        send_item(CMD_READ, 31, 31, 1'b0, 64'd0);
        send_item(CMD_READ, 31, 31, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        drain();
        cfg_write(REG_FULL_SIZE, 6'd3);
        cfg_write(REG_KEPT_SIZE, 6'd1);
        cfg_write(REG_MASS_ENABLE, 6'd1);
        load_block(3, 1'b1, -1);
        start_item();
        send_item(CMD_READ, 0, 0, 1'b0, 64'd0);
        send_item(CMD_READ, 0, 0, 1'b1, 64'd0);
        drain();

        run_phase(6'd2, 6'd1, 1'b0);
        hold_req = ~hold_req;
        burst_left = 40;
        repeat (30) read_any();
        drain();

        while (items_sent < 560) begin
            full = 6'($urandom_range(2, 8));
            kept = 6'($urandom_range(1, full));
            case ($urandom_range(0, 9))
                0: full = 6'd0;
                1: kept = 6'd0;
                2: kept = 6'($urandom_range(full, 63));
                3: if (!big_done) begin
                    full = 6'd12;
                    kept = 6'd9;
                    big_done = 1'b1;
                end
                4: kept = full;
                default: ;
            endcase
            run_phase(full, kept, 1'($urandom_range(0, 1)));
        end
        run_phase(6'd10, 6'd1, 1'b1);

        drain();
        repeat (100) @(negedge aclk);
        $display("Covered %0d items, %0d results checked, %0d condensations (%0d zero pivot).",
                 items_sent, checked_cnt, done_cnt, zero_pivot_cnt);
        $display("Sizes ran from one to twelve DOF plus out-of-range settings, with and without mass reduction.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
